// ----- hw/rtl/kdlp_pkg.sv -----
// Package for the key debounce / long-press scanner with event queue.
// Holds register indexes, reset values, opcodes and event codes.
// No dependencies.
package kdlp_pkg;

  localparam int unsigned MaxKeysDefault   = 2;
  localparam int unsigned FifoDepthDefault = 8;

  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgAddrWidth-1:0] REG_ACTIVE_KEYS = 2'd0;
  localparam logic [CfgAddrWidth-1:0] REG_FILTER_CNT  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] REG_LONG_FIRST  = 2'd2;
  localparam logic [CfgAddrWidth-1:0] REG_LONG_SECOND = 2'd3;

  localparam logic [1:0]  ACTIVE_KEYS_RST = 2'd2;
  localparam logic [7:0]  FILTER_CNT_RST  = 8'd5;
  localparam logic [15:0] LONG_FIRST_RST  = 16'd200;
  localparam logic [15:0] LONG_SECOND_RST = 16'd400;

  localparam logic [15:0] HOLD_MAX = 16'hffff;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LONG1   = 2'd2;
  localparam logic [1:0] KIND_LONG2   = 2'd3;

  typedef struct packed {
    logic [1:0] key_number;
    logic [1:0] event_kind;
  } event_t;

endpackage

// ----- hw/rtl/key_debounce_longpress_fifo.sv -----
// Key debounce scanner with long-press detection and an event queue.
// Depends on kdlp_pkg for codes, reset values and the event type.
//
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// request  | in_valid_i/in_ready_o, op_i, key_pressed_i     | in
// result   | out_valid_o/out_ready_i, event_present_o,      | out
//          | key_number_o, event_kind_o                     |
// config   | cfg_we_i, cfg_addr_i, cfg_wdata_i              | in
//
// One request per cycle while in_ready_o is high: key state, queue pointers
// and the output (or skid) register are all updated at the accepting edge.
// A skid register behind the output keeps requests flowing while a result
// waits; in_ready_o drops only when both output slots hold results.
// Reset clears key state, queue pointers and count; queue entries are not reset.
module key_debounce_longpress_fifo
  import kdlp_pkg::*;
#(
  parameter int unsigned MAX_KEYS   = MaxKeysDefault,
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kdlp_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [kdlp_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [1:0]                          key_pressed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                event_present_o,
  output logic [1:0]                          key_number_o,
  output logic [1:0]                          event_kind_o
);

  localparam int unsigned NS = 2 * MAX_KEYS;
  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = $clog2(FIFO_DEPTH + NS + 1);

  // configuration
  logic [1:0]  active_keys_q;
  logic [7:0]  filter_cnt_q;
  logic [15:0] long_first_q;
  logic [15:0] long_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_keys_q <= ACTIVE_KEYS_RST;
      filter_cnt_q  <= FILTER_CNT_RST;
      long_first_q  <= LONG_FIRST_RST;
      long_second_q <= LONG_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ACTIVE_KEYS: active_keys_q <= cfg_wdata_i[1:0];
        REG_FILTER_CNT:  filter_cnt_q  <= cfg_wdata_i[7:0];
        REG_LONG_FIRST:  long_first_q  <= cfg_wdata_i;
        REG_LONG_SECOND: long_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic out_valid_q, skid_valid_q;
  logic out_take;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // per-key state
  logic [MAX_KEYS-1:0] filt_q, filt_d;
  logic [MAX_KEYS-1:0] lvl_q, lvl_d;
  logic [7:0]          deb_q  [MAX_KEYS];
  logic [7:0]          deb_d  [MAX_KEYS];
  logic [15:0]         hold_q [MAX_KEYS];
  logic [15:0]         hold_d [MAX_KEYS];

  logic [MAX_KEYS-1:0] lvl_in;
  logic [MAX_KEYS-1:0] scan;

  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_key
    localparam logic [3:0] KIDX = 4'(k);
    if (k < 2) begin : g_bit
      assign lvl_in[k] = key_pressed_i[k];
    end else begin : g_none
      assign lvl_in[k] = 1'b0;
    end
    assign scan[k] = KIDX < {2'b00, active_keys_q};
  end

  logic [NS-1:0] want;
  event_t        slot_ev [NS];

  always_comb begin
    logic [15:0] hn;
    logic [7:0]  dn;
    hn     = '0;
    dn     = '0;
    filt_d = filt_q;
    lvl_d  = lvl_q;
    deb_d  = deb_q;
    hold_d = hold_q;
    want   = '0;
    for (int k = 0; k < MAX_KEYS; k++) begin
      slot_ev[2*k].key_number   = 2'(k + 1);
      slot_ev[2*k].event_kind   = KIND_LONG1;
      slot_ev[2*k+1].key_number = 2'(k + 1);
      slot_ev[2*k+1].event_kind = KIND_LONG2;
      if (in_acc && op_i == OP_TICK && scan[k]) begin
        if (!filt_q[k]) begin
          if (lvl_in[k] != lvl_q[k]) begin
            lvl_d[k]  = lvl_in[k];
            deb_d[k]  = '0;
            filt_d[k] = 1'b1;
          end else if (lvl_in[k] && hold_q[k] != HOLD_MAX) begin
            hn        = hold_q[k] + 16'd1;
            hold_d[k] = hn;
            want[2*k]   = (hn == long_first_q);
            want[2*k+1] = (hn == long_second_q);
          end
        end else if (lvl_in[k] == lvl_q[k]) begin
          dn       = deb_q[k] + 8'd1;
          deb_d[k] = dn;
          if (dn >= filter_cnt_q) begin
            want[2*k] = 1'b1;
            slot_ev[2*k].event_kind = lvl_in[k] ? KIND_PRESS : KIND_RELEASE;
            if (lvl_in[k]) begin
              hold_d[k] = '0;
            end
            filt_d[k] = 1'b0;
          end
        end else begin
          lvl_d[k]  = lvl_in[k];
          filt_d[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      lvl_q  <= '0;
      for (int k = 0; k < MAX_KEYS; k++) begin
        deb_q[k]  <= '0;
        hold_q[k] <= '0;
      end
    end else begin
      filt_q <= filt_d;
      lvl_q  <= lvl_d;
      deb_q  <= deb_d;
      hold_q <= hold_d;
    end
  end

  // event queue
  event_t          store_q [FIFO_DEPTH];
  logic [PW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NS-1:0]   wr_en;
  logic [PW-1:0]   wr_addr [NS];
  event_t          rd_ev;
  logic            res_present;
  event_t          res_ev;

  assign rd_ev = store_q[rp_q];

  always_comb begin
    logic [SW-1:0] pos;
    logic [SW-1:0] a;
    pos         = '0;
    a           = '0;
    wr_en       = '0;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    res_present = 1'b0;
    res_ev      = '0;
    for (int j = 0; j < NS; j++) begin
      wr_addr[j] = '0;
      if (want[j] && (SW'(cnt_q) + pos < SW'(FIFO_DEPTH))) begin
        a = SW'(wp_q) + pos;
        if (a >= SW'(FIFO_DEPTH)) begin
          a = a - SW'(FIFO_DEPTH);
        end
        wr_en[j]   = 1'b1;
        wr_addr[j] = a[PW-1:0];
        pos        = pos + SW'(1);
      end
    end
    a = SW'(wp_q) + pos;
    if (a >= SW'(FIFO_DEPTH)) begin
      a = a - SW'(FIFO_DEPTH);
    end
    wp_d  = a[PW-1:0];
    cnt_d = CW'(SW'(cnt_q) + pos);
    if (in_acc && op_i == OP_READ && cnt_q != '0) begin
      res_present = 1'b1;
      res_ev      = rd_ev;
      cnt_d       = cnt_q - CW'(1);
      rp_d        = (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NS; j++) begin
      if (wr_en[j]) begin
        store_q[wr_addr[j]] <= slot_ev[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  // output register and skid slot
  logic   out_present_q, skid_present_q;
  event_t out_ev_q, skid_ev_q;
  logic   rd_acc;

  assign rd_acc = in_acc && op_i == OP_READ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (rd_acc) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_present_q <= skid_present_q;
        out_ev_q      <= skid_ev_q;
      end
    end else if (rd_acc) begin
      if (!out_valid_q || out_take) begin
        out_present_q <= res_present;
        out_ev_q      <= res_ev;
      end else begin
        skid_present_q <= res_present;
        skid_ev_q      <= res_ev;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_present_o = out_present_q;
  assign key_number_o    = out_ev_q.key_number;
  assign event_kind_o    = out_ev_q.event_kind;

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for key_debounce_longpress_fifo: directed table, then random scan/read traffic.
// Tracks debounce, hold and event queue state alongside the DUT and checks every read result.
// Depends on kdlp_pkg and the key_debounce_longpress_fifo RTL.
`timescale 1ns / 1ps

module testbench;
  import kdlp_pkg::*;

  typedef struct packed {
    logic       present;
    logic [1:0] key_number;
    logic [1:0] event_kind;
  } result_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [CfgAddrWidth-1:0] addr;
    logic [CfgDataWidth-1:0] data;
    logic                    op;
    logic [1:0]              keys;
    logic [17:0]             reps;
    logic                    typed;
    result_t                 want;
  } step_t;

  localparam logic    ROW_REQ  = 1'b0;
  localparam logic    ROW_CFG  = 1'b1;
  localparam result_t NO_EVENT = '0;
  localparam int      SETTLE_CYCLES = 4;
  localparam int      DIRECTED_ROWS = 30;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgAddrWidth-1:0] cfg_addr_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    op_i;
  logic [1:0]              key_pressed_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    event_present_o;
  logic [1:0]              key_number_o;
  logic [1:0]              event_kind_o;

  key_debounce_longpress_fifo DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .key_pressed_i  (key_pressed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_present_o(event_present_o),
    .key_number_o   (key_number_o),
    .event_kind_o   (event_kind_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow configuration and key state
  logic [1:0]  cfg_active     = ACTIVE_KEYS_RST;
  logic [7:0]  cfg_filter     = FILTER_CNT_RST;
  logic [15:0] cfg_long_first = LONG_FIRST_RST;
  logic [15:0] cfg_long_second = LONG_SECOND_RST;
  logic        key_filtering [MaxKeysDefault] = '{default: 1'b0};
  logic        key_level     [MaxKeysDefault] = '{default: 1'b0};
  logic [7:0]  key_debounce  [MaxKeysDefault] = '{default: 8'd0};
  logic [15:0] key_hold      [MaxKeysDefault] = '{default: 16'd0};
  event_t      queued_events [$];
  result_t     expected_reads [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  step_t directed_plan [0:DIRECTED_ROWS-1] = '{
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd1,     1'b1, NO_EVENT},
    '{ROW_CFG, REG_FILTER_CNT,  16'd1,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd1,     1'b1,
      '{1'b1, 2'd1, KIND_PRESS}},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b11, 18'd1,     1'b1,
      '{1'b1, 2'd2, KIND_PRESS}},
    '{ROW_CFG, REG_LONG_FIRST,  16'd2,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_LONG_SECOND, 16'd3,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd4,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd5,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b01, 18'd1,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd1,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_FILTER_CNT,  16'd0,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b00, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b00, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b00, 18'd2,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd9,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b11, 18'd3,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd1,     1'b1, NO_EVENT},
    '{ROW_CFG, REG_ACTIVE_KEYS, 16'd3,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_FILTER_CNT,  16'd1,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_LONG_FIRST,  16'd0,     OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_LONG_SECOND, 16'hffff,  OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    // hold key 0 with the first threshold at zero
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b01, 18'd8,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd3,     1'b0, NO_EVENT},
    '{ROW_CFG, REG_FILTER_CNT,  16'd255,   OP_TICK, 2'b00, 18'd0,     1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_TICK, 2'b10, 18'd256,   1'b0, NO_EVENT},
    '{ROW_REQ, REG_ACTIVE_KEYS, 16'd0,     OP_READ, 2'b00, 18'd3,     1'b0, NO_EVENT}
  };

  function automatic void queue_event(int k, logic [1:0] kind);
    event_t e;
    if (queued_events.size() < FifoDepthDefault) begin
      e.key_number = 2'(k + 1);
      e.event_kind = kind;
      queued_events.push_back(e);
    end
  endfunction

  function automatic void scan_keys(logic [1:0] pressed);
    int   n;
    logic lvl;
    n = (cfg_active > MaxKeysDefault) ? MaxKeysDefault : cfg_active;
    for (int k = 0; k < n; k++) begin
      lvl = pressed[k];
      if (!key_filtering[k]) begin
        if (lvl != key_level[k]) begin
          key_level[k]     = lvl;
          key_debounce[k]  = 8'd0;
          key_filtering[k] = 1'b1;
        end else if (lvl && key_hold[k] != HOLD_MAX) begin
          key_hold[k] = key_hold[k] + 16'd1;
          if (key_hold[k] == cfg_long_first) queue_event(k, KIND_LONG1);
          if (key_hold[k] == cfg_long_second) queue_event(k, KIND_LONG2);
        end
      end else if (lvl == key_level[k]) begin
        key_debounce[k] = key_debounce[k] + 8'd1;
        if (key_debounce[k] >= cfg_filter) begin
          if (lvl) begin
            queue_event(k, KIND_PRESS);
            key_hold[k] = 16'd0;
          end else begin
            queue_event(k, KIND_RELEASE);
          end
          key_filtering[k] = 1'b0;
        end
      end else begin
        key_level[k]     = lvl;
        key_filtering[k] = 1'b0;
      end
    end
  endfunction

  function automatic result_t pop_queued_event();
    event_t e;
    if (queued_events.size() == 0) return NO_EVENT;
    e = queued_events.pop_front();
    return '{1'b1, e.key_number, e.event_kind};
  endfunction

  function automatic void check_result();
    result_t seen;
    result_t want;
    seen = {event_present_o, key_number_o, event_kind_o};
    if (expected_reads.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: result with nothing pending: present=%0d key=%0d kind=%0d",
                 $realtime, seen.present, seen.key_number, seen.event_kind);
      return;
    end
    want = expected_reads.pop_front();
    if (seen.present != want.present || seen.key_number != want.key_number ||
        seen.event_kind != want.event_kind) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: read mismatch: exp present=%0d key=%0d kind=%0d, got %0d/%0d/%0d",
                 $realtime, want.present, want.key_number, want.event_kind,
                 seen.present, seen.key_number, seen.event_kind);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic issue_request(logic op, logic [1:0] keys, logic typed, result_t want);
    result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    key_pressed_i <= keys;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_READ) begin
      got = pop_queued_event();
      expected_reads.push_back(typed ? want : got);
    end else begin
      scan_keys(keys);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgAddrWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ACTIVE_KEYS: cfg_active      = value[1:0];
      REG_FILTER_CNT:  cfg_filter      = value[7:0];
      REG_LONG_FIRST:  cfg_long_first  = value;
      REG_LONG_SECOND: cfg_long_second = value;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return HOLD_MAX;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(1, 5));
    endcase
  endfunction

  // mostly stable key runs long enough to pass debounce, with glitches and reads mixed in
  task automatic random_traffic(int count);
    int         done;
    int         span;
    logic [1:0] held;
    done = 0;
    while (done < count) begin
      held = 2'($urandom_range(3));
      if ($urandom_range(5) == 0) span = $urandom_range(10, 40);
      else if (cfg_filter > 8) span = $urandom_range(1, 12);
      else span = $urandom_range(1, cfg_filter + 4);
      for (int j = 0; j < span && done < count; j++) begin
        if ($urandom_range(99) < 25)
          issue_request(OP_READ, 2'($urandom_range(3)), 1'b0, NO_EVENT);
        else if ($urandom_range(99) < 8)
          issue_request(OP_TICK, 2'($urandom_range(3)), 1'b0, NO_EVENT);
        else
          issue_request(OP_TICK, held, 1'b0, NO_EVENT);
        done++;
        if ($urandom_range(59) == 0) drain_results();
      end
    end
  endtask

  initial begin
    int send_modes [4];
    int recv_modes [4];
    step_t row;
    send_modes = '{0, 68, 0, 21};
    recv_modes = '{0, 0, 68, 21};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= REG_ACTIVE_KEYS;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_TICK;
    key_pressed_i <= 2'b00;
    out_ready_i   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_plan[i];
      if (row.is_cfg) begin
        write_register(row.addr, row.data);
      end else begin
        for (int r = 0; r < row.reps; r++)
          issue_request(row.op, row.keys, row.typed, row.want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_modes[p];
      recv_stall_pct = recv_modes[p];
      for (int s = 0; s < 2; s++) begin
        write_register(REG_ACTIVE_KEYS, 16'($urandom_range(3)));
        write_register(REG_FILTER_CNT, {8'd0, pick_filter()});
        write_register(REG_LONG_FIRST, pick_threshold());
        write_register(REG_LONG_SECOND, pick_threshold());
        random_traffic(18);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- key_debounce_longpress_fifo.f -----
hw/rtl/kdlp_pkg.sv
hw/rtl/key_debounce_longpress_fifo.sv
verif/testbench.sv
